// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the wavetable voice mixer.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define WVM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("wavetable_voice_mixer assertion failed");
// Check a property on every clock edge, reset included.
`define WVM_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("wavetable_voice_mixer assertion failed");
`else
`define WVM_ASSERT(lbl, prop)
`define WVM_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- rtl/wvm_pkg.sv -----
// Package for the wavetable voice mixer: sizes, operation codes and the
// request type of the shared multiplier. No dependencies.
package wvm_pkg;

    localparam int VOICES     = 4;
    localparam int WAVE_SLOTS = 6;
    localparam int ENV_SLOTS  = 4;
    localparam int TABLE_LEN  = 256;

    localparam int WAVE_DEPTH = WAVE_SLOTS * TABLE_LEN;
    localparam int ENV_DEPTH  = ENV_SLOTS * TABLE_LEN;
    localparam int WAVE_AW    = $clog2(WAVE_DEPTH);
    localparam int ENV_AW     = $clog2(ENV_DEPTH);

    // Operation codes carried in s_tuser
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_SET_VOICE = 3'd1;
    localparam logic [2:0] OP_TRIG_NOTE = 3'd2;
    localparam logic [2:0] OP_TRIGGER   = 3'd3;
    localparam logic [2:0] OP_RELEASE   = 3'd4;
    localparam logic [2:0] OP_WR_WAVE   = 3'd5;
    localparam logic [2:0] OP_WR_ENV    = 3'd6;

    // Shared multiplier operand and product widths
    localparam int MUL_AW = 14;
    localparam int MUL_BW = 11;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    typedef struct packed {
        logic signed [MUL_AW-1:0] a;
        logic signed [MUL_BW-1:0] b;
    } mul_req_t;

endpackage

// ----- rtl/wvm_mult.sv -----
// Shared signed multiplier of the wavetable voice mixer, one registered
// product per cycle. Depends on wvm_pkg.
module wvm_mult import wvm_pkg::*; (
    input  logic                     aclk,
    input  mul_req_t                 req,
    output logic signed [MUL_PW-1:0] prod_reg
);

    logic signed [MUL_PW-1:0] prod_next;

    // Multiply the request operands
    assign prod_next = MUL_PW'(req.a) * MUL_PW'(req.b);

    // Register the product
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

// ----- rtl/wavetable_voice_mixer.sv -----
// Top level of the four-voice wavetable voice mixer: sequencer, voice state,
// wave and envelope table memories and output register.
// Depends on wvm_pkg, wvm_mult and assert_macros.svh.
//
// Usage: items enter on the s_ channel (operation in s_tuser, the other
// fields packed in s_tdata). A tick produces one transfer on the m_ channel
// carrying the PWM duty value, the frame flag and the free-voice mask; all
// other operations update state and produce nothing.
// A tick goes from acceptance to the result through one envelope step, one
// envelope table read, three steps per voice (wave read, multiply,
// accumulate), three steps of tuning refresh through the shared
// multiplier and one to load the output register. When the stepped voice
// is free the envelope table read is skipped.
// Set voice with pitch or modulation and trigger note go through the same
// refresh; other operations finish on acceptance. s_tready is high
// only while the sequencer is idle, so one item is worked on at a time.
// After reset the block sweeps the wave and envelope tables to zero, one
// entry per cycle, with s_tready held low during the sweep.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and only a following tick result waits for it to drain.
module wavetable_voice_mixer import wvm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] voice, [6:2] field_mask, [9:7] wave_select, [11:10] envelope_select,
    // [27:12] pitch_word, [43:28] envelope_speed, [51:44] mod_code,
    // [59:52] table_index, [67:60] table_data, [71:68] zero
    input  logic [71:0] s_tdata,
    // [2:0] operation
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] sample_out, [8] frame_tick, [12:9] free_mask, [15:13] zero
    output logic [15:0] m_tdata
);

`include "assert_macros.svh"

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_ENV  = 4'd2;
    localparam logic [3:0] ST_AMP  = 4'd3;
    localparam logic [3:0] ST_WRD  = 4'd4;
    localparam logic [3:0] ST_WMUL = 4'd5;
    localparam logic [3:0] ST_WACC = 4'd6;
    localparam logic [3:0] ST_TUN1 = 4'd7;
    localparam logic [3:0] ST_TUN2 = 4'd8;
    localparam logic [3:0] ST_TUN3 = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;

    localparam int VW = $clog2(VOICES);

    // Input fields
    logic [2:0]  op;
    logic [1:0]  in_voice;
    logic [4:0]  in_mask;
    logic [2:0]  in_ws;
    logic [1:0]  in_es;
    logic [15:0] in_pitch;
    logic [15:0] in_speed;
    logic [7:0]  in_modc;
    logic [7:0]  in_idx;
    logic [7:0]  in_data;

    assign op       = s_tuser;
    assign in_voice = s_tdata[1:0];
    assign in_mask  = s_tdata[6:2];
    assign in_ws    = s_tdata[9:7];
    assign in_es    = s_tdata[11:10];
    assign in_pitch = s_tdata[27:12];
    assign in_speed = s_tdata[43:28];
    assign in_modc  = s_tdata[51:44];
    assign in_idx   = s_tdata[59:52];
    assign in_data  = s_tdata[67:60];

    // Voice state
    logic [15:0] wave_phase_reg [VOICES];
    logic [15:0] tuning_reg     [VOICES];
    logic [7:0]  amp_reg        [VOICES];
    logic [15:0] base_reg       [VOICES];
    logic [8:0]  mod_reg        [VOICES];
    logic [2:0]  wslot_reg      [VOICES];
    logic [1:0]  eslot_reg      [VOICES];
    logic [15:0] env_phase_reg  [VOICES];
    logic [15:0] env_step_reg   [VOICES];

    // Table memories
    logic [7:0] wave_ram [WAVE_DEPTH];
    logic [7:0] env_ram  [ENV_DEPTH];

    logic [3:0]         st_reg;
    logic [1:0]         div_reg;
    logic [VW-1:0]      vidx_reg;
    logic [VW-1:0]      dsel_reg;
    logic               tick_reg;
    logic [WAVE_AW-1:0] clr_reg;
    logic signed [10:0] mix_reg;
    logic [7:0]         wave_rd_reg;
    logic [7:0]         env_rd_reg;
    logic               m_tvalid_reg;
    logic [15:0]        m_tdata_reg;

    logic               s_fire;
    logic [1:0]         div_next;
    logic [15:0]        phase_sum;
    logic [15:0]        env_sum;
    logic               wave_we;
    logic [WAVE_AW-1:0] wave_waddr;
    logic [7:0]         wave_wdata;
    logic [WAVE_AW-1:0] wave_raddr;
    logic               env_we;
    logic [ENV_AW-1:0]  env_waddr;
    logic [7:0]         env_wdata;
    logic [ENV_AW-1:0]  env_raddr;
    mul_req_t           mreq;
    logic signed [MUL_PW-1:0] prod;
    logic signed [10:0] mix_quarter;
    logic signed [10:0] mix_clamped;
    logic signed [MUL_PW-1:0] tune_sum;
    logic [15:0]        tune_clamped;
    logic [3:0]         free_mask;
    logic               out_free;

    assign s_tready = (st_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign div_next = div_reg + 2'd1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Phase sums of the voice under work
    assign phase_sum = wave_phase_reg[vidx_reg] + tuning_reg[vidx_reg];
    assign env_sum   = env_phase_reg[vidx_reg] + env_step_reg[vidx_reg];

    // Table write ports: clearing sweep or table write transfer
    always_comb begin
        wave_we    = 1'b0;
        wave_waddr = clr_reg;
        wave_wdata = 8'd0;
        env_we     = 1'b0;
        env_waddr  = clr_reg[ENV_AW-1:0];
        env_wdata  = 8'd0;
        if (st_reg == ST_CLR) begin
            wave_we = 1'b1;
            env_we  = (32'(clr_reg) < ENV_DEPTH);
        end else if (s_fire) begin
            wave_waddr = {in_ws, in_idx};
            wave_wdata = in_data;
            env_waddr  = {in_es, in_idx};
            env_wdata  = in_data;
            wave_we    = (op == OP_WR_WAVE) && (32'(in_ws) < WAVE_SLOTS);
            env_we     = (op == OP_WR_ENV) && (32'(in_es) < ENV_SLOTS);
        end
    end

    assign wave_raddr = {wslot_reg[vidx_reg], phase_sum[15:8]};
    assign env_raddr  = {eslot_reg[vidx_reg], env_sum[15:8]};

    // Wave table memory
    always_ff @(posedge aclk) begin
        if (wave_we) begin
            wave_ram[wave_waddr] <= wave_wdata;
        end
        wave_rd_reg <= wave_ram[wave_raddr];
    end

    // Envelope table memory
    always_ff @(posedge aclk) begin
        if (env_we) begin
            env_ram[env_waddr] <= env_wdata;
        end
        env_rd_reg <= env_ram[env_raddr];
    end

    // Select the multiplier operands for the current step
    always_comb begin
        mreq.a = '0;
        mreq.b = '0;
        unique case (st_reg)
            ST_TUN1: begin
                mreq.a = MUL_AW'({1'b0, base_reg[vidx_reg][15:6]});
                mreq.b = MUL_BW'({1'b0, env_phase_reg[vidx_reg][15:6]});
            end
            ST_TUN2: begin
                mreq.a = MUL_AW'({1'b0, prod[19:7]});
                mreq.b = MUL_BW'(signed'(mod_reg[vidx_reg]));
            end
            ST_WMUL: begin
                mreq.a = MUL_AW'(signed'(wave_rd_reg));
                mreq.b = MUL_BW'({1'b0, amp_reg[vidx_reg]});
            end
            default: begin
                mreq.a = '0;
                mreq.b = '0;
            end
        endcase
    end

    wvm_mult u_mult (
        .aclk     (aclk),
        .req      (mreq),
        .prod_reg (prod)
    );

    // Mix scaling and clamping
    assign mix_quarter = mix_reg >>> 2;
    always_comb begin
        if (mix_quarter < -11'sd127) begin
            mix_clamped = -11'sd127;
        end else if (mix_quarter > 11'sd127) begin
            mix_clamped = 11'sd127;
        end else begin
            mix_clamped = mix_quarter;
        end
    end

    // Modulated tuning word, clamped to the unsigned 16-bit range
    assign tune_sum = signed'(MUL_PW'(base_reg[vidx_reg])) + prod;
    always_comb begin
        if (tune_sum[MUL_PW-1]) begin
            tune_clamped = 16'd0;
        end else if (|tune_sum[MUL_PW-2:16]) begin
            tune_clamped = 16'hFFFF;
        end else begin
            tune_clamped = tune_sum[15:0];
        end
    end

    // Free mask: absent voices read as free
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            free_mask[i] = (i >= VOICES) ? 1'b1 : env_phase_reg[VW'(i)][15];
        end
    end

    // Sequencer and voice state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_CLR;
            clr_reg      <= '0;
            div_reg      <= 2'd0;
            vidx_reg     <= '0;
            dsel_reg     <= '0;
            tick_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < VOICES; i++) begin
                wave_phase_reg[i] <= 16'd0;
                tuning_reg[i]     <= 16'd0;
                amp_reg[i]        <= 8'd0;
                base_reg[i]       <= 16'd0;
                mod_reg[i]        <= 9'd0;
                wslot_reg[i]      <= 3'd0;
                eslot_reg[i]      <= 2'd0;
                env_phase_reg[i]  <= 16'h8000;
                env_step_reg[i]   <= 16'd0;
            end
        end else begin
            // Drop the result once the receiver takes it
            if (m_tvalid_reg && m_tready && (st_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (st_reg)
                ST_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == WAVE_DEPTH - 1) begin
                        st_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        tick_reg <= (op == OP_TICK);
                        vidx_reg <= (op == OP_TICK) ? VW'(div_next) : VW'(in_voice);
                        unique case (op)
                            OP_TICK: begin
                                div_reg  <= div_next;
                                dsel_reg <= VW'(div_next);
                                st_reg   <= ST_ENV;
                            end
                            OP_SET_VOICE: begin
                                if (in_mask[0]) begin
                                    wslot_reg[VW'(in_voice)] <=
                                        (32'(in_ws) < WAVE_SLOTS) ? in_ws : 3'd0;
                                end
                                if (in_mask[1]) begin
                                    base_reg[VW'(in_voice)] <= in_pitch;
                                end
                                if (in_mask[2]) begin
                                    eslot_reg[VW'(in_voice)] <=
                                        (32'(in_es) < ENV_SLOTS) ? in_es : 2'd0;
                                end
                                if (in_mask[3]) begin
                                    env_step_reg[VW'(in_voice)] <= in_speed;
                                end
                                if (in_mask[4]) begin
                                    mod_reg[VW'(in_voice)] <= {1'b0, in_modc} - 9'd64;
                                end
                                if (in_mask[1] || in_mask[4]) begin
                                    st_reg <= ST_TUN1;
                                end
                            end
                            OP_TRIG_NOTE: begin
                                base_reg[VW'(in_voice)]      <= in_pitch;
                                env_phase_reg[VW'(in_voice)] <= 16'd0;
                                st_reg                       <= ST_TUN1;
                            end
                            OP_TRIGGER: begin
                                env_phase_reg[VW'(in_voice)] <= 16'd0;
                                tuning_reg[VW'(in_voice)]    <= base_reg[VW'(in_voice)];
                            end
                            OP_RELEASE: begin
                                env_phase_reg[VW'(in_voice)] <= 16'h8000;
                                amp_reg[VW'(in_voice)]       <= 8'd0;
                            end
                            default: begin
                                st_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                // Step the envelope of the selected voice, or clear its amplitude when it is free
                ST_ENV: begin
                    if (env_phase_reg[vidx_reg][15]) begin
                        amp_reg[vidx_reg] <= 8'd0;
                        vidx_reg          <= '0;
                        st_reg            <= ST_WRD;
                    end else begin
                        env_phase_reg[vidx_reg] <= env_sum;
                        st_reg                  <= ST_AMP;
                    end
                end
                ST_AMP: begin
                    amp_reg[vidx_reg] <= env_rd_reg;
                    vidx_reg          <= '0;
                    mix_reg           <= '0;
                    st_reg            <= ST_WRD;
                end
                // Advance the wave phase and read its sample
                ST_WRD: begin
                    if (vidx_reg == '0) begin
                        mix_reg <= '0;
                    end
                    wave_phase_reg[vidx_reg] <= phase_sum;
                    st_reg                   <= ST_WMUL;
                end
                ST_WMUL: begin
                    st_reg <= ST_WACC;
                end
                ST_WACC: begin
                    mix_reg <= mix_reg + prod[18:8];
                    if (32'(vidx_reg) == VOICES - 1) begin
                        vidx_reg <= dsel_reg;
                        st_reg   <= ST_TUN1;
                    end else begin
                        vidx_reg <= vidx_reg + 1'b1;
                        st_reg   <= ST_WRD;
                    end
                end
                ST_TUN1: begin
                    st_reg <= ST_TUN2;
                end
                ST_TUN2: begin
                    st_reg <= ST_TUN3;
                end
                // Write the refreshed tuning word
                ST_TUN3: begin
                    tuning_reg[vidx_reg] <= tune_clamped;
                    st_reg <= tick_reg ? ST_OUT : ST_IDLE;
                end
                // Hold until the output register is free
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {3'd0, free_mask, (div_reg == 2'd0),
                                         8'(mix_clamped + 11'sd127)};
                        st_reg       <= ST_IDLE;
                    end
                end
                default: begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `WVM_ASSERT_ALWAYS(a_reset_blocks_input, !aresetn |=> !s_tready)
    `WVM_ASSERT(a_clear_blocks_input, (st_reg == ST_CLR) |-> !s_tready)
    `WVM_ASSERT(a_sample_in_range, m_tvalid |-> (m_tdata[7:0] != 8'hFF))

endmodule

// ----- sim/wavetable_voice_mixer_tb.sv -----
// Self-checking testbench for wavetable_voice_mixer: drives operations over the
// s_ stream, predicts each tick result and compares it with the m_ stream.
// Depends on wvm_pkg and the RTL of the block.
module wavetable_voice_mixer_tb;
    import wvm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCH_LIMIT = 20000;

    typedef struct packed {
        logic [3:0] free;
        logic       frame;
        logic [7:0] sample;
    } mix_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    wavetable_voice_mixer i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Predictor state
    logic [15:0] pr_phase [VOICES];
    logic [15:0] pr_tune [VOICES];
    logic [7:0]  pr_amp [VOICES];
    logic [15:0] pr_base [VOICES];
    int          pr_depth [VOICES];
    logic [2:0]  pr_wslot [VOICES];
    logic [1:0]  pr_eslot [VOICES];
    logic [15:0] pr_env [VOICES];
    logic [15:0] pr_estep [VOICES];
    logic [1:0]  pr_div;
    logic [7:0]  pr_wave [WAVE_DEPTH];
    logic [7:0]  pr_envtab [ENV_DEPTH];

    mix_result_t expected_mix [$];
    int  error_count = 0;
    int  idle_cycles = 0;
    bit  hold_off = 0;

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    function automatic int floor_shift(int v, int sh);
        return v >>> sh;
    endfunction

    function automatic void refresh_tune(int v);
        int base, scaled, r;
        base = pr_base[v];
        scaled = int'((longint'(pr_base[v] >> 6) * longint'(pr_env[v] >> 6)) >> 7);
        r = base + scaled * pr_depth[v];
        if (r < 0) r = 0;
        else if (r > 65535) r = 65535;
        pr_tune[v] = r[15:0];
    endfunction

    function automatic void predict_reset();
        for (int i = 0; i < VOICES; i++) begin
            pr_phase[i] = 0; pr_tune[i] = 0; pr_amp[i] = 0; pr_base[i] = 0;
            pr_depth[i] = 0; pr_wslot[i] = 0; pr_eslot[i] = 0;
            pr_env[i] = 16'h8000; pr_estep[i] = 0;
        end
        pr_div = 0;
        foreach (pr_wave[i]) pr_wave[i] = 0;
        foreach (pr_envtab[i]) pr_envtab[i] = 0;
    endfunction

    // Apply one item to the predictor and queue the tick result if any
    function automatic void predict_item(logic [2:0] op, logic [71:0] d);
        logic [1:0]  v;
        logic [4:0]  mask;
        logic [2:0]  ws;
        logic [1:0]  es;
        logic [7:0]  idx, dat;
        int mix, s, dv;
        logic [3:0] fm;
        mix_result_t res;
        v = d[1:0]; mask = d[6:2]; ws = d[9:7]; es = d[11:10];
        idx = d[59:52]; dat = d[67:60];
        case (op)
            OP_TICK: begin
                pr_div = pr_div + 2'd1;
                dv = pr_div;
                if (pr_env[dv][15]) pr_amp[dv] = 0;
                else begin
                    pr_env[dv] = pr_env[dv] + pr_estep[dv];
                    pr_amp[dv] = pr_envtab[pr_eslot[dv] * TABLE_LEN + pr_env[dv][15:8]];
                end
                mix = 0;
                for (int i = 0; i < VOICES; i++) begin
                    pr_phase[i] = pr_phase[i] + pr_tune[i];
                    s = $signed(pr_wave[pr_wslot[i] * TABLE_LEN + pr_phase[i][15:8]]);
                    mix += floor_shift(s * int'(pr_amp[i]), 8);
                end
                mix = floor_shift(mix, 2);
                if (mix < -127) mix = -127;
                else if (mix > 127) mix = 127;
                refresh_tune(dv);
                for (int i = 0; i < 4; i++) fm[i] = pr_env[i][15];
                res.sample = 8'(127 + mix);
                res.frame = (dv == 0);
                res.free = fm;
                expected_mix.push_back(res);
            end
            OP_SET_VOICE: begin
                if (mask[0]) pr_wslot[v] = (ws < WAVE_SLOTS) ? ws : 3'd0;
                if (mask[1]) begin pr_base[v] = d[27:12]; refresh_tune(v); end
                if (mask[2]) pr_eslot[v] = (es < ENV_SLOTS) ? es : 2'd0;
                if (mask[3]) pr_estep[v] = d[43:28];
                if (mask[4]) begin pr_depth[v] = int'(d[51:44]) - 64; refresh_tune(v); end
            end
            OP_TRIG_NOTE: begin
                pr_base[v] = d[27:12]; pr_env[v] = 0; refresh_tune(v);
            end
            OP_TRIGGER: begin
                pr_env[v] = 0; pr_tune[v] = pr_base[v];
            end
            OP_RELEASE: begin
                pr_env[v] = 16'h8000; pr_amp[v] = 0;
            end
            OP_WR_WAVE: if (ws < WAVE_SLOTS) pr_wave[ws * TABLE_LEN + idx] = dat;
            OP_WR_ENV:  if (es < ENV_SLOTS) pr_envtab[es * TABLE_LEN + idx] = dat;
            default: ;
        endcase
    endfunction

    function automatic logic [71:0] pack_item(logic [1:0] v, logic [4:0] mask,
            logic [2:0] ws, logic [1:0] es, logic [15:0] pitch, logic [15:0] speed,
            logic [7:0] modc, logic [7:0] idx, logic [7:0] dat);
        return {4'd0, dat, idx, modc, speed, pitch, es, ws, mask, v};
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Send one item after a random gap and wait for the transfer
    task automatic send_item(logic [2:0] op, logic [71:0] d);
        int gap;
        gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1; s_tuser <= op; s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        predict_item(op, d);
    endtask

    task automatic send_random(int n, bit musical);
        logic [2:0] op;
        for (int k = 0; k < n; k++) begin
            if (musical) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: op = OP_TICK;
                    5: op = OP_SET_VOICE;
                    6: op = OP_TRIG_NOTE;
                    7: op = ($urandom_range(0, 1)) ? OP_TRIGGER : OP_RELEASE;
                    default: op = ($urandom_range(0, 1)) ? OP_WR_WAVE : OP_WR_ENV;
                endcase
            end else op = 3'($urandom_range(0, 7));
            send_item(op, pack_item(2'($urandom), 5'($urandom), 3'($urandom),
                2'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom)));
        end
    endtask

    task automatic test_directed();
        // Load extreme table entries so ticks produce full-scale samples
        for (int i = 0; i < 4; i++)
            send_item(OP_WR_WAVE, pack_item(0, 0, 3'(i), 0, 0, 0, 0, 8'(i), 8'h80));
        send_item(OP_WR_WAVE, pack_item(0, 0, 3'd6, 0, 0, 0, 0, 8'd0, 8'h7F));
        send_item(OP_WR_ENV, pack_item(0, 0, 0, 2'd0, 0, 0, 0, 8'd0, 8'hFF));
        send_item(OP_WR_ENV, pack_item(0, 0, 0, 2'd3, 0, 0, 0, 8'hFF, 8'hFF));
        send_item(OP_SET_VOICE, pack_item(2'd1, 5'h1F, 3'd7, 2'd3, 16'hFFFF, 16'h0000,
            8'hFF, 0, 0));
        send_item(OP_SET_VOICE, pack_item(2'd2, 5'h1F, 3'd5, 2'd0, 16'h0000, 16'hFFFF,
            8'h00, 0, 0));
        send_item(OP_TRIG_NOTE, pack_item(2'd3, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0));
        send_item(OP_TRIGGER, pack_item(2'd1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(OP_TRIGGER, pack_item(2'd2, 0, 0, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < 8; i++) send_item(OP_TICK, '0);
        send_item(OP_RELEASE, pack_item(2'd1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(3'd7, '1);
        send_item(OP_TICK, '1);
        send_item(OP_TICK, '0);
    endtask

    task automatic test_random();
        send_random(400, 1);
        send_random(60, 0);
    endtask

    // Hold the receiver off for a long stretch while items keep coming
    task automatic test_backpressure();
        hold_off = 1;
        fork
            begin
                for (int i = 0; i < 200; i++) @(posedge aclk);
                hold_off = 0;
            end
            for (int k = 0; k < 6; k++) send_item(OP_TICK, '0);
        join
    endtask

    // Receiver side: random stalls, check each transfer
    initial begin
        int stall;
        mix_result_t got, want;
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (m_tready && m_tvalid) begin
                got = m_tdata[12:0];
                if (expected_mix.size() == 0) begin
                    $display("unexpected result %h at %0t", m_tdata, $time);
                    error_count++;
                end else begin
                    want = expected_mix.pop_front();
                    if (got.sample !== want.sample)
                        report_mismatch("sample_out", got.sample, want.sample);
                    if (got.frame !== want.frame)
                        report_mismatch("frame_tick", got.frame, want.frame);
                    if (got.free !== want.free)
                        report_mismatch("free_mask", got.free, want.free);
                end
                stall = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
                m_tready <= (stall == 0 && !hold_off);
            end else if (!m_tready && !hold_off) begin
                if (stall > 0) stall--;
                else m_tready <= 1;
            end else if (hold_off) m_tready <= 0;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCH_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int waited;
        aresetn <= 0; s_tvalid <= 0; s_tuser <= '0; s_tdata <= '0;
        predict_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        test_directed();
        test_backpressure();
        test_random();
        s_tvalid <= 0;
        waited = 0;
        while (expected_mix.size() != 0 && waited < WATCH_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (40) @(posedge aclk);
        if (error_count == 0 && expected_mix.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
